// ----- rtl/cartridge_bank_mapper_top_defines.svh -----
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartridge bank mapper: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartridge bank mapper: next-cycle check failed");

`endif

// ----- rtl/cbm_pkg.sv -----
// Types and constants shared by the cartridge bank mapper modules.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam logic [1:0] ACT_CPU_WRITE = 2'd0;
    localparam logic [1:0] ACT_CPU_READ  = 2'd1;
    localparam logic [1:0] ACT_PPU_READ  = 2'd2;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_CHR  = 2'd2;

    localparam logic [0:0] CFG_PRG_BANK_BITS = 1'd0;
    localparam logic [0:0] CFG_CHR_BANK_BITS = 1'd1;

    localparam logic [3:0] PRG_BITS_RESET = 4'd5;
    localparam logic [3:0] CHR_BITS_RESET = 4'd8;

    localparam logic [7:0] BANK_LAST   = 8'hFF;
    localparam logic [7:0] BANK_SECOND = 8'hFE;

    localparam int CTRL_INDEX_BIT  = 0;
    localparam int CTRL_PRG_MODE   = 6;
    localparam int CTRL_CHR_INVERT = 7;

    typedef struct packed {
        logic [3:0]      prg_bits;
        logic [3:0]      chr_bits;
        logic            prg_mode;
        logic            chr_invert;
        logic [7:0][7:0] regs;
    } t_map_ctl;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] rom_address;
        logic [7:0]  bank_number;
    } t_result;

    // Bank count mask; register values above 8 act as 8.
    function automatic logic [7:0] bank_mask(input logic [3:0] bits);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (4'(i) < bits);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cbm_map.sv -----
// Address translation: one bus request to a PRG or CHR ROM address, or to no target.
`timescale 1ns / 1ps
`default_nettype none

module cbm_map (
    input  wire logic [1:0]       i_action,
    input  wire logic [15:0]      i_address,
    input  wire cbm_pkg::t_map_ctl i_ctl,
    output cbm_pkg::t_result      o_result
);

    logic [7:0] prg_raw;
    logic [7:0] chr_raw;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic [2:0] chr_win;
    logic       is_prg;
    logic       is_chr;

    always_comb begin
        case (i_address[14:13])
            2'd0:    prg_raw = i_ctl.prg_mode ? cbm_pkg::BANK_SECOND : i_ctl.regs[6];
            2'd1:    prg_raw = i_ctl.regs[7];
            2'd2:    prg_raw = i_ctl.prg_mode ? i_ctl.regs[6] : cbm_pkg::BANK_SECOND;
            default: prg_raw = cbm_pkg::BANK_LAST;
        endcase
    end

    assign chr_win = {i_address[12] ^ i_ctl.chr_invert, i_address[11:10]};

    always_comb begin
        case (chr_win)
            3'd0:    chr_raw = i_ctl.regs[0];
            3'd1:    chr_raw = i_ctl.regs[0] + 8'd1;
            3'd2:    chr_raw = i_ctl.regs[1];
            3'd3:    chr_raw = i_ctl.regs[1] + 8'd1;
            3'd4:    chr_raw = i_ctl.regs[2];
            3'd5:    chr_raw = i_ctl.regs[3];
            3'd6:    chr_raw = i_ctl.regs[4];
            default: chr_raw = i_ctl.regs[5];
        endcase
    end

    assign prg_bank = prg_raw & cbm_pkg::bank_mask(i_ctl.prg_bits);
    assign chr_bank = chr_raw & cbm_pkg::bank_mask(i_ctl.chr_bits);

    assign is_prg = (i_action == cbm_pkg::ACT_CPU_READ) && i_address[15];
    assign is_chr = (i_action == cbm_pkg::ACT_PPU_READ) && (i_address[15:13] == 3'd0);

    always_comb begin
        if (is_prg) begin
            o_result.target      = cbm_pkg::TGT_PRG;
            o_result.rom_address = {prg_bank, i_address[12:0]};
            o_result.bank_number = prg_bank;
        end else if (is_chr) begin
            o_result.target      = cbm_pkg::TGT_CHR;
            o_result.rom_address = {3'd0, chr_bank, i_address[9:0]};
            o_result.bank_number = chr_bank;
        end else begin
            o_result.target      = cbm_pkg::TGT_NONE;
            o_result.rom_address = 21'd0;
            o_result.bank_number = 8'd0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cartridge_bank_mapper_top.sv -----
// Top level of the cartridge bank mapper: control state, mapping, output buffer.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_action, i_address, i_write_data
//  result    out        o_valid / i_stall   o_target, o_rom_address, o_bank_number
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; its result is registered in the output
// register, or in the skid entry while the output is held by i_stall.
// A two-entry output buffer (register plus skid) keeps accepting while one
// result waits; o_stall rises only when both entries are full.
// Synchronous reset clears the bank registers, index and mode bits and sets the bank-bit widths to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_mapper_top_defines.svh"

module cartridge_bank_mapper_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_target,
    output logic [20:0]      o_rom_address,
    output logic [7:0]       o_bank_number,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    logic [3:0]      r_prg_bits;
    logic [3:0]      r_chr_bits;
    logic [2:0]      r_bank_index;
    logic            r_prg_mode;
    logic            r_chr_invert;
    logic [7:0][7:0] r_regs;

    logic              r_out_valid;
    cbm_pkg::t_result  r_out;
    logic              r_skid_valid;
    cbm_pkg::t_result  r_skid;

    cbm_pkg::t_map_ctl map_ctl;
    cbm_pkg::t_result  n_result;
    logic              accept;
    logic              out_free;
    logic              ctrl_write;

    assign map_ctl.prg_bits   = r_prg_bits;
    assign map_ctl.chr_bits   = r_chr_bits;
    assign map_ctl.prg_mode   = r_prg_mode;
    assign map_ctl.chr_invert = r_chr_invert;
    assign map_ctl.regs       = r_regs;

    cbm_map u_map (
        .i_action  (i_action),
        .i_address (i_address),
        .i_ctl     (map_ctl),
        .o_result  (n_result)
    );

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign ctrl_write = accept && (i_action == cbm_pkg::ACT_CPU_WRITE)
                        && (i_address[15:13] == 3'b100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bits   <= cbm_pkg::PRG_BITS_RESET;
            r_chr_bits   <= cbm_pkg::CHR_BITS_RESET;
            r_bank_index <= 3'd0;
            r_prg_mode   <= 1'b0;
            r_chr_invert <= 1'b0;
            r_regs       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbm_pkg::CFG_PRG_BANK_BITS: r_prg_bits <= i_cfg_data;
                    cbm_pkg::CFG_CHR_BANK_BITS: r_chr_bits <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ctrl_write) begin
                if (!i_address[cbm_pkg::CTRL_INDEX_BIT]) begin
                    r_bank_index <= i_write_data[2:0];
                    r_prg_mode   <= i_write_data[cbm_pkg::CTRL_PRG_MODE];
                    r_chr_invert <= i_write_data[cbm_pkg::CTRL_CHR_INVERT];
                end else begin
                    r_regs[r_bank_index] <= i_write_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_target      = r_out.target;
    assign o_rom_address = r_out.rom_address;
    assign o_bank_number = r_out.bank_number;

    // skid entry is only used behind a held output
    `CBM_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

    // no-target results carry zero address and bank
    `CBM_ASSERT_NOW(a_none_is_zero, i_clk, i_rst_n,
        o_valid && (o_target == cbm_pkg::TGT_NONE),
        (o_rom_address == 21'd0) && (o_bank_number == 8'd0))

    // a bank data write lands in the register picked by the bank index
    `CBM_ASSERT_NEXT(a_bank_write, i_clk, i_rst_n,
        ctrl_write && i_address[cbm_pkg::CTRL_INDEX_BIT],
        r_regs[$past(r_bank_index)] == $past(i_write_data))

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for cartridge_bank_mapper_top: random bus accesses checked against a bank predictor.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] ACT_IDLE    = 2'd3;
    localparam logic [2:0] CTRL_PAGE   = 3'b100;
    localparam logic [2:0] PATTERN_PAGE = 3'b000;
    localparam int         PRG_SLOT_A  = 6;
    localparam int         PRG_SLOT_B  = 7;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASE_REQS  = 229;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
    } t_bus_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_target;
    logic [20:0] o_rom_address;
    logic [7:0]  o_bank_number;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;

    cartridge_bank_mapper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_target      (o_target),
        .o_rom_address (o_rom_address),
        .o_bank_number (o_bank_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mapper state as seen by the predictor
    logic [3:0]      prg_bits;
    logic [3:0]      chr_bits;
    logic [2:0]      sel_index;
    logic            prg_swap;
    logic            chr_swap;
    logic [7:0]      bank_reg [8];

    t_bus_req         bus_reqs [$];
    cbm_pkg::t_result results_due [$];
    int       queued_cnt;
    int       accepted_cnt;
    int       err_cnt;
    int       quiet_cycles;
    bit       req_taken;
    int       burst_left;
    int       gap_left;
    int       stall_mode;
    int       stall_left;
    int       stall_tick;
    t_bus_req drv_req;
    cbm_pkg::t_result want;
    bit       progress;

    function automatic logic [7:0] wrap_mask(input logic [3:0] bits);
        return (bits >= 4'd8) ? 8'hFF : 8'((9'd1 << bits) - 9'd1);
    endfunction

    function automatic cbm_pkg::t_result map_access(input logic [1:0] act,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data);
        cbm_pkg::t_result r;
        logic [7:0] raw;
        logic [7:0] bank;
        logic [2:0] win;
        r = '0;
        case (act)
            cbm_pkg::ACT_CPU_WRITE: begin
                if (addr[15:13] == CTRL_PAGE) begin
                    if (!addr[0]) begin
                        sel_index = data[2:0];
                        prg_swap  = data[cbm_pkg::CTRL_PRG_MODE];
                        chr_swap  = data[cbm_pkg::CTRL_CHR_INVERT];
                    end else begin
                        bank_reg[sel_index] = data;
                    end
                end
            end
            cbm_pkg::ACT_CPU_READ: begin
                if (addr[15]) begin
                    case (addr[14:13])
                        2'd0: raw = prg_swap ? cbm_pkg::BANK_SECOND : bank_reg[PRG_SLOT_A];
                        2'd1: raw = bank_reg[PRG_SLOT_B];
                        2'd2: raw = prg_swap ? bank_reg[PRG_SLOT_A] : cbm_pkg::BANK_SECOND;
                        default: raw = cbm_pkg::BANK_LAST;
                    endcase
                    bank = raw & wrap_mask(prg_bits);
                    r.target      = cbm_pkg::TGT_PRG;
                    r.rom_address = {bank, addr[12:0]};
                    r.bank_number = bank;
                end
            end
            cbm_pkg::ACT_PPU_READ: begin
                if (addr[15:13] == PATTERN_PAGE) begin
                    win = addr[12:10] ^ {chr_swap, 2'b00};
                    case (win)
                        3'd0: raw = bank_reg[0];
                        3'd1: raw = bank_reg[0] + 8'd1;
                        3'd2: raw = bank_reg[1];
                        3'd3: raw = bank_reg[1] + 8'd1;
                        default: raw = bank_reg[win - 3'd2];
                    endcase
                    bank = raw & wrap_mask(chr_bits);
                    r.target      = cbm_pkg::TGT_CHR;
                    r.rom_address = {3'b000, bank, addr[9:0]};
                    r.bank_number = bank;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_req(input logic [1:0] act, input logic [15:0] addr, input logic [7:0] data);
        bus_reqs.push_back('{act, addr, data});
        queued_cnt++;
    endtask

    // mostly select/load pairs and in-range reads, some stray addresses and idle codes
    task automatic add_random();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            add_req(cbm_pkg::ACT_CPU_WRITE, {CTRL_PAGE, 12'($urandom), 1'b0}, 8'($urandom));
            add_req(cbm_pkg::ACT_CPU_WRITE, {CTRL_PAGE, 12'($urandom), 1'b1}, 8'($urandom));
        end else if (sel < 20) begin
            add_req(cbm_pkg::ACT_CPU_WRITE, {CTRL_PAGE, 13'($urandom)}, 8'($urandom));
        end else if (sel < 24) begin
            add_req(cbm_pkg::ACT_CPU_WRITE, 16'($urandom), 8'($urandom));
        end else if (sel < 54) begin
            add_req(cbm_pkg::ACT_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
        end else if (sel < 58) begin
            add_req(cbm_pkg::ACT_CPU_READ, 16'($urandom), 8'($urandom));
        end else if (sel < 90) begin
            add_req(cbm_pkg::ACT_PPU_READ, {PATTERN_PAGE, 13'($urandom)}, 8'($urandom));
        end else if (sel < 95) begin
            add_req(cbm_pkg::ACT_PPU_READ, 16'($urandom), 8'($urandom));
        end else begin
            add_req(ACT_IDLE, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_cnt != queued_cnt || results_due.size() != 0);
    endtask

    task automatic write_config(input logic [3:0] prg, input logic [3:0] chr);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cbm_pkg::CFG_PRG_BANK_BITS;
        i_cfg_data  <= prg;
        @(negedge i_clk);
        i_cfg_index <= cbm_pkg::CFG_CHR_BANK_BITS;
        i_cfg_data  <= chr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        prg_bits = prg;
        chr_bits = chr;
    endtask

    task automatic run_phase(input logic [3:0] prg, input logic [3:0] chr);
        int stop_at;
        wait_drained();
        write_config(prg, chr);
        stop_at = queued_cnt + PHASE_REQS;
        while (queued_cnt < stop_at) add_random();
    endtask

    // request driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (bus_reqs.size() != 0) begin
                drv_req = bus_reqs.pop_front();
                i_valid      <= 1'b1;
                i_action     <= drv_req.action;
                i_address    <= drv_req.address;
                i_write_data <= drv_req.data;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(1) == 0) gap_left = 0;
                    else if ($urandom_range(7) == 0) gap_left = $urandom_range(10, 40);
                    else gap_left = $urandom_range(1, 4);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result stall pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(3) == 0);
            2: i_stall <= ($urandom_range(3) != 0);
            default: i_stall <= (stall_tick % 5 < 2);
        endcase
    end

    // monitor: predict on request, check on result, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_valid && !o_stall) begin
                req_taken = 1'b1;
                accepted_cnt++;
                results_due.push_back(map_access(i_action, i_address, i_write_data));
                progress = 1'b1;
            end
            if (o_valid && !i_stall) begin
                progress = 1'b1;
                if (results_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t unexpected result: expected none, %s %0d addr %0h bank %0d",
                             $time, "got target", o_target, o_rom_address, o_bank_number);
                end else begin
                    want = results_due.pop_front();
                    if (o_target !== want.target) begin
                        err_cnt++;
                        $display("%0t target: expected %0d, got %0d",
                                 $time, want.target, o_target);
                    end
                    if (o_rom_address !== want.rom_address) begin
                        err_cnt++;
                        $display("%0t rom_address: expected %0h, got %0h",
                                 $time, want.rom_address, o_rom_address);
                    end
                    if (o_bank_number !== want.bank_number) begin
                        err_cnt++;
                        $display("%0t bank_number: expected %0d, got %0d",
                                 $time, want.bank_number, o_bank_number);
                    end
                end
            end
            if (progress) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = cbm_pkg::ACT_CPU_WRITE;
        i_address    = '0;
        i_write_data = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = cbm_pkg::CFG_PRG_BANK_BITS;
        i_cfg_data   = '0;
        prg_bits     = cbm_pkg::PRG_BITS_RESET;
        chr_bits     = cbm_pkg::CHR_BITS_RESET;
        sel_index    = '0;
        prg_swap     = 1'b0;
        chr_swap     = 1'b0;
        for (int i = 0; i < 8; i++) bank_reg[i] = '0;
        queued_cnt   = 0;
        accepted_cnt = 0;
        err_cnt      = 0;
        quiet_cycles = 0;
        req_taken    = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        stall_mode   = 0;
        stall_left   = 0;
        stall_tick   = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, fixed banks, mode and inversion, wrap of reg+1, no-target cases
        add_req(cbm_pkg::ACT_PPU_READ,  16'h0000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_READ,  16'hE000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_READ,  16'hC000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h8000, 8'h06);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h8001, 8'hFF);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h9FFE, 8'h07);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h9FFF, 8'h80);
        add_req(cbm_pkg::ACT_CPU_READ,  16'h8000, 8'hFF);
        add_req(cbm_pkg::ACT_CPU_READ,  16'hA000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_READ,  16'hFFFF, 8'h00);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h8000, 8'h46);
        add_req(cbm_pkg::ACT_CPU_READ,  16'h8000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_READ,  16'hC000, 8'h00);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h8000, 8'h80);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h8001, 8'hFF);
        add_req(cbm_pkg::ACT_PPU_READ,  16'h1000, 8'h00);
        add_req(cbm_pkg::ACT_PPU_READ,  16'h17FF, 8'h00);
        add_req(cbm_pkg::ACT_PPU_READ,  16'h1FFF, 8'h00);
        add_req(cbm_pkg::ACT_PPU_READ,  16'h0400, 8'h00);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'hA001, 8'h55);
        add_req(cbm_pkg::ACT_CPU_WRITE, 16'h7FFE, 8'hAA);
        add_req(cbm_pkg::ACT_CPU_READ,  16'h7FFF, 8'hFF);
        add_req(cbm_pkg::ACT_PPU_READ,  16'h2000, 8'h00);
        add_req(ACT_IDLE,               16'hFFFF, 8'hFF);
        begin : reset_phase
            int stop_at;
            stop_at = queued_cnt + PHASE_REQS;
            while (queued_cnt < stop_at) add_random();
        end

        run_phase(4'd1, 4'd0);
        run_phase(4'd8, 4'd8);
        run_phase(4'd0, 4'd15);
        run_phase(4'd15, 4'd1);
        run_phase(4'd4, 4'd3);
        run_phase(4'($urandom), 4'($urandom));
        run_phase(4'($urandom), 4'($urandom));

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
